// ===== design/bctd_pkg.sv =====
// Shared types, constants and arithmetic helpers for the texture block decoder.
package bctd_pkg;

    localparam int InDataW   = 128;   // color_end0, color_end1, color_indices, alpha_data
    localparam int OutDataW  = 40;    // red, green, blue, alpha, texel_pos, zero fill
    localparam int FmtW      = 2;
    localparam int Texels    = 16;
    localparam int PosW      = 4;

    // Reciprocals for constant division: floor(n * M >> k) == floor(n / d).
    localparam logic [15:0] Recip124 = 16'd33826;   // k = 22, n < 2^15
    localparam logic [16:0] Recip252 = 17'd66577;   // k = 24, n < 2^16
    localparam logic [12:0] Recip14  = 13'd4682;    // k = 16, n < 2^12
    localparam logic [12:0] Recip10  = 13'd6554;    // k = 16, n < 2^12

    typedef enum logic [FmtW-1:0] {
        FMT_DXT1 = 2'd0,
        FMT_DXT3 = 2'd1,
        FMT_DXT5 = 2'd2
    } t_fmt;

    typedef enum logic [1:0] {
        PAL_END0 = 2'd0,
        PAL_END1 = 2'd1,
        PAL_MIX1 = 2'd2,
        PAL_MIX2 = 2'd3
    } t_pal;

    // Palette entry as a sum s such that the channel value is round(s * 85 / D),
    // D = 62 for 5-bit and 126 for 6-bit channels.
    function automatic logic [8:0] pal_sum(input logic [5:0] e0, input logic [5:0] e1,
                                           input logic [1:0] ci, input logic four);
        logic [8:0] s;
        case (t_pal'(ci))
            PAL_END0: s = 9'(e0) * 9'd6;
            PAL_END1: s = 9'(e1) * 9'd6;
            PAL_MIX1: s = four ? (9'(e0) * 9'd4 + 9'(e1) * 9'd2)
                               : (9'(e0) * 9'd3 + 9'(e1) * 9'd3);
            default:  s = four ? (9'(e0) * 9'd2 + 9'(e1) * 9'd4) : 9'd0;
        endcase
        return s;
    endfunction

    // round(s * 85 / 62) for 5-bit channels, s <= 186
    function automatic logic [7:0] unorm5(input logic [8:0] s);
        logic [14:0] n;
        logic [30:0] p;
        n = 15'(s) * 15'd170 + 15'd62;
        p = 31'(n) * 31'(Recip124);
        return p[29:22];
    endfunction

    // round(s * 85 / 126) for 6-bit channels, s <= 378
    function automatic logic [7:0] unorm6(input logic [8:0] s);
        logic [15:0] n;
        logic [32:0] p;
        n = 16'(s) * 16'd170 + 16'd126;
        p = 33'(n) * 33'(Recip252);
        return p[31:24];
    endfunction

    // Interpolated alpha: entries 0/1 are the endpoints, eight-step ramp when
    // a0 > a1, else six-step ramp with fixed black and white at the top codes.
    function automatic logic [7:0] ramp_alpha(input logic [7:0] a0, input logic [7:0] a1,
                                              input logic [2:0] j);
        logic        eight;
        logic [3:0]  w0;
        logic [3:0]  w1;
        logic [10:0] n;
        logic [11:0] t;
        logic [24:0] p;
        logic [7:0]  q;
        eight = a0 > a1;
        w0    = eight ? (4'd8 - 4'(j)) : (4'd6 - 4'(j));
        w1    = 4'(j) - 4'd1;
        n     = 11'(w0) * 11'(a0) + 11'(w1) * 11'(a1);
        t     = {n, 1'b0} + (eight ? 12'd7 : 12'd5);
        p     = 25'(t) * 25'(eight ? Recip14 : Recip10);
        if (j == 3'd0) begin
            q = a0;
        end else if (j == 3'd1) begin
            q = a1;
        end else if (!eight && j == 3'd6) begin
            q = 8'd0;
        end else if (!eight && j == 3'd7) begin
            q = 8'd255;
        end else begin
            q = p[23:16];
        end
        return q;
    endfunction

endpackage

// ===== design/bc_texture_block_decoder.sv =====
// Top level of the DXT1/DXT3/DXT5 texture block decoder.
// Takes one 128-bit compressed 4x4 block per input item and emits its sixteen
// texels in row-major order, one texel per output item, tlast on texel 15.
// The block sits in a holding register while a 4-bit texel counter walks it;
// each cycle the selected texel is decoded by short logic (palette select, one
// constant-reciprocal multiply per channel, alpha select) into the output
// register. The single output channel carries one texel per cycle while not stalled;
// the next block is taken in the cycle its predecessor's last texel moves to the
// output register, so blocks stream with no gap. Output backpressure stalls the
// counter; nothing is dropped. The format register (0 DXT1, 1 DXT3, 2 DXT5, 3
// decodes as DXT1) is to be written by the user only while idle; the block itself
// does not enforce this.
module bc_texture_block_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bctd_pkg::FmtW-1:0]     i_cfg_wdata,      // block_format
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // color_end0[15:0], color_end1[31:16], color_indices[63:32], alpha_data[127:64]
    input  logic [bctd_pkg::InDataW-1:0]  i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24], texel_pos[35:32], zero[39:36]
    output logic [bctd_pkg::OutDataW-1:0] o_m_axis_tdata,
    output logic                          o_m_axis_tlast    // last_texel
);
    import bctd_pkg::*;

    // control state
    t_fmt            r_fmt;
    logic            r_blk_valid;
    logic [PosW-1:0] r_cnt;
    logic            r_out_valid;

    // held block
    logic [15:0]     r_c0;
    logic [15:0]     r_c1;
    logic [31:0]     r_idx;
    logic [63:0]     r_adata;

    // output register
    logic [7:0]      r_red;
    logic [7:0]      r_green;
    logic [7:0]      r_blue;
    logic [7:0]      r_alpha;
    logic [PosW-1:0] r_pos;
    logic            r_last;

    logic            s_fire;
    logic            adv;
    logic            last_cnt;

    logic            is_dxt3;
    logic            is_dxt5;
    logic            four;
    logic [1:0]      ci;
    logic [3:0]      nib;
    logic [2:0]      aj;
    logic [8:0]      s_red;
    logic [8:0]      s_green;
    logic [8:0]      s_blue;
    logic [7:0]      n_red;
    logic [7:0]      n_green;
    logic [7:0]      n_blue;
    logic [7:0]      n_alpha;

    // Advance the counter whenever a texel can move into the output register.
    assign adv             = r_blk_valid && (!r_out_valid || i_m_axis_tready);
    assign last_cnt        = (r_cnt == PosW'(Texels - 1));
    assign o_s_axis_tready = !r_blk_valid || (adv && last_cnt);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    // Format decode; code 3 falls through to DXT1.
    always_comb begin
        is_dxt3 = 1'b0;
        is_dxt5 = 1'b0;
        unique case (r_fmt)
            FMT_DXT3: is_dxt3 = 1'b1;
            FMT_DXT5: is_dxt5 = 1'b1;
            default:  ;
        endcase
    end

    // Texel decode for the current counter position.
    assign four = is_dxt3 || is_dxt5 || (r_c0 > r_c1);
    assign ci   = r_idx[{r_cnt, 1'b0} +: 2];
    assign nib  = r_adata[{r_cnt, 2'b00} +: 4];
    assign aj   = r_adata[6'd16 + 6'(r_cnt) * 6'd3 +: 3];

    assign s_red   = pal_sum({1'b0, r_c0[15:11]}, {1'b0, r_c1[15:11]}, ci, four);
    assign s_green = pal_sum(r_c0[10:5], r_c1[10:5], ci, four);
    assign s_blue  = pal_sum({1'b0, r_c0[4:0]}, {1'b0, r_c1[4:0]}, ci, four);

    assign n_red   = unorm5(s_red);
    assign n_green = unorm6(s_green);
    assign n_blue  = unorm5(s_blue);

    always_comb begin
        if (is_dxt3) begin
            n_alpha = {nib, nib};
        end else if (is_dxt5) begin
            n_alpha = ramp_alpha(r_adata[7:0], r_adata[15:8], aj);
        end else begin
            // three-color mode: entry 3 is transparent black
            n_alpha = (!four && t_pal'(ci) == PAL_MIX2) ? 8'd0 : 8'd255;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt       <= FMT_DXT1;
            r_blk_valid <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fmt <= t_fmt'(i_cfg_wdata);
            end
            // hold the block until its last texel advances, then take the next
            if (s_fire) begin
                r_blk_valid <= 1'b1;
                r_cnt       <= '0;
            end else if (adv) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_cnt) begin
                    r_blk_valid <= 1'b0;
                end
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_c0    <= i_s_axis_tdata[15:0];
            r_c1    <= i_s_axis_tdata[31:16];
            r_idx   <= i_s_axis_tdata[63:32];
            r_adata <= i_s_axis_tdata[127:64];
        end
        if (adv) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_alpha <= n_alpha;
            r_pos   <= r_cnt;
            r_last  <= last_cnt;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_pos, r_alpha, r_blue, r_green, r_red};
    assign o_m_axis_tlast  = r_last;

`ifndef ASSERT_OFF
    // a newly taken block starts at texel 0
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_blk_valid && r_cnt == '0)
        else $error("block not started at texel 0");

    // a block is never released before its last texel
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !last_cnt |=> r_blk_valid)
        else $error("block released early");

    // the output register shows the texel the counter pointed at
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_m_axis_tvalid && o_m_axis_tdata[35:32] == $past(r_cnt)
                && o_m_axis_tlast == ($past(r_cnt) == PosW'(Texels - 1)))
        else $error("texel position mismatch");
`endif

endmodule
